>>> rtl/image_resize_to_argb1555_defines.svh
// assertion macros for the image scaler
`ifndef IMAGE_RESIZE_TO_ARGB1555_DEFINES_SVH
`define IMAGE_RESIZE_TO_ARGB1555_DEFINES_SVH

`ifndef SYNTHESIS
`define IRS_ASSERT_NOW(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error("image scaler check failed");
`define IRS_ASSERT_NEXT(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error("image scaler check failed");
`else
`define IRS_ASSERT_NOW(label, clk, rst_n, cond, conseq)
`define IRS_ASSERT_NEXT(label, clk, rst_n, cond, conseq)
`endif

`endif

>>> rtl/irs_pkg.sv
package irs_pkg;

    localparam int DIM_W = 9;
    localparam int COL_W = 8;
    localparam int Q_W = 17;
    localparam int NUM_W = 26;
    localparam int SUM_W = 24;
    localparam int W_W = 17;
    localparam int PIX_W = 24;

    typedef enum logic [2:0] {
        REG_SRC_WIDTH  = 3'd0,
        REG_SRC_HEIGHT = 3'd1,
        REG_DST_HEIGHT = 3'd2,
        REG_FIRST_COL  = 3'd3,
        REG_END_COL    = 3'd4
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_READ,
        ST_ACC
    } state_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DIM_W-1:0] den;
    } div_req_t;

    function automatic logic [15:0] pack_1555(input logic [PIX_W-1:0] t);
        pack_1555 = {1'b1, t[23:19], t[15:11], t[7:3]};
    endfunction

endpackage

>>> rtl/irs_div.sv
module irs_div
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  irs_pkg::div_req_t            req,
    output logic                         done,
    output logic [irs_pkg::Q_W-1:0]      quo
);

    logic                          run_reg, run_next;
    logic                          done_reg, done_next;
    logic [4:0]                    cnt_reg, cnt_next;
    logic [irs_pkg::DIM_W-1:0]     rem_reg, rem_next;
    logic [irs_pkg::Q_W-1:0]       num_reg, num_next;
    logic [irs_pkg::Q_W-1:0]       quo_reg, quo_next;
    logic [irs_pkg::DIM_W:0]       trial;
    logic [irs_pkg::DIM_W:0]       den_ext;
    logic [irs_pkg::DIM_W-1:0]     den_reg, den_next;

    assign trial   = {rem_reg, num_reg[irs_pkg::Q_W-1]};
    assign den_ext = {1'b0, den_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        num_next  = num_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (req.start)
        begin
            // quotient fits in Q_W bits, so the top slice is already below den
            run_next = 1'b1;
            cnt_next = '0;
            rem_next = req.num[irs_pkg::NUM_W-1:irs_pkg::Q_W];
            num_next = req.num[irs_pkg::Q_W-1:0];
            den_next = req.den;
        end
        else if (run_reg)
        begin
            if (trial >= den_ext)
            begin
                rem_next = irs_pkg::DIM_W'(trial - den_ext);
                quo_next = {quo_reg[irs_pkg::Q_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[irs_pkg::DIM_W-1:0];
                quo_next = {quo_reg[irs_pkg::Q_W-2:0], 1'b0};
            end
            num_next = {num_reg[irs_pkg::Q_W-2:0], 1'b0};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'(irs_pkg::Q_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        num_reg <= num_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

>>> rtl/image_resize_to_argb1555.sv
// Image scaler. A start with cmd 0 stores one XRGB8888 pixel in raster
// order; busy stays low. A start with cmd 1 produces the next ARGB1555
// destination pixel: four serial divisions (each a multiply step, a 17-bit
// quotient found bit by bit, and a hand-off) find the source positions and
// weights, then the single-port pixel memory is read once per texel, with a
// read and an accumulate state per texel, for four texels with blending and
// one with point sampling. done pulses for one cycle in the same cycle that
// busy falls, and the block can take the next start in that same cycle.
// The receiver cannot stall, so done, dest_pixel and last must be
// captured in the one cycle that done is high.
`include "image_resize_to_argb1555_defines.svh"

module image_resize_to_argb1555
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cmd,
    input  logic [31:0] pixel,
    output logic        done,
    output logic [15:0] dest_pixel,
    output logic        last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = (ADR_W + 1 > 19) ? ADR_W + 1 : 19;
    localparam int DW = irs_pkg::DIM_W;

    // configuration
    logic [DW-1:0]             src_w_reg, src_h_reg, dst_h_reg, end_col_reg;
    logic [irs_pkg::COL_W-1:0] first_col_reg;
    logic                      cfg_we;
    logic [2:0]                cfg_idx;

    logic [DW-1:0] sw, sh, dh, ec, fc, dw;
    logic [irs_pkg::COL_W-1:0] fc8;

    irs_pkg::state_t state_reg, state_next;
    logic [ADR_W-1:0] load_idx_reg, load_idx_next;
    logic [DW-1:0] out_row_reg, out_row_next, out_col_reg, out_col_next;
    logic [DW-1:0] row_reg, row_next, col_reg, col_next, c_reg, c_next;
    logic [1:0] k_reg, k_next, tj_reg, tj_next;
    logic [irs_pkg::Q_W-1:0] res_reg [4];
    logic [irs_pkg::Q_W-1:0] res_next [4];
    logic [irs_pkg::W_W-1:0] w_reg, w_next;
    logic [irs_pkg::SUM_W-1:0] sum_reg [3];
    logic [irs_pkg::SUM_W-1:0] sum_next [3];
    logic [irs_pkg::SUM_W-1:0] sum_acc [3];
    logic [15:0] dest_pixel_reg, dest_pixel_next;
    logic last_reg, last_next, done_reg, done_next;

    logic [irs_pkg::PIX_W-1:0] mem [DEPTH];
    logic [irs_pkg::PIX_W-1:0] rd_data_reg;
    logic mem_we;
    logic [ADR_W-1:0] mem_addr, tex_addr;

    irs_pkg::div_req_t div_req;
    logic div_done;
    logic [irs_pkg::Q_W-1:0] div_quo;

    logic point;
    logic [CNT_W-1:0] load_inc, area;
    logic [DW-1:0] div_i, div_s;
    logic [DW-1:0] r0, r1, c0, c1, tex_r, tex_c;
    logic [DW-1:0] top, left, wa, wb;
    logic [DW:0] r1_t, c1_t;
    logic [DW-1:0] row_n, col_n;
    logic [DW:0] col_inc, row_inc;
    logic [2*DW-1:0] tex_prod;

    // register port
    assign cfg_we  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg     <= DW'(1);
            src_h_reg     <= DW'(1);
            dst_h_reg     <= DW'(1);
            first_col_reg <= '0;
            end_col_reg   <= DW'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                irs_pkg::REG_SRC_WIDTH:  src_w_reg     <= pwdata[DW-1:0];
                irs_pkg::REG_SRC_HEIGHT: src_h_reg     <= pwdata[DW-1:0];
                irs_pkg::REG_DST_HEIGHT: dst_h_reg     <= pwdata[DW-1:0];
                irs_pkg::REG_FIRST_COL:  first_col_reg <= pwdata[irs_pkg::COL_W-1:0];
                irs_pkg::REG_END_COL:    end_col_reg   <= pwdata[DW-1:0];
                default:                 ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            irs_pkg::REG_SRC_WIDTH:  prdata = {23'b0, src_w_reg};
            irs_pkg::REG_SRC_HEIGHT: prdata = {23'b0, src_h_reg};
            irs_pkg::REG_DST_HEIGHT: prdata = {23'b0, dst_h_reg};
            irs_pkg::REG_FIRST_COL:  prdata = {24'b0, first_col_reg};
            irs_pkg::REG_END_COL:    prdata = {23'b0, end_col_reg};
            default:                 prdata = '0;
        endcase
    end

    // effective sizes, saturated to the supported range
    always_comb
    begin
        sw = (src_w_reg == '0) ? DW'(1) :
             (int'(src_w_reg) > MAX_WIDTH) ? DW'(MAX_WIDTH) : src_w_reg;
        sh = (src_h_reg == '0) ? DW'(1) :
             (int'(src_h_reg) > MAX_HEIGHT) ? DW'(MAX_HEIGHT) : src_h_reg;
        dh = (dst_h_reg == '0) ? DW'(1) :
             (int'(dst_h_reg) > MAX_HEIGHT) ? DW'(MAX_HEIGHT) : dst_h_reg;
        fc8 = (int'(first_col_reg) > MAX_WIDTH - 1) ?
              irs_pkg::COL_W'(MAX_WIDTH - 1) : first_col_reg;
        fc = {1'b0, fc8};
        ec = (end_col_reg < fc + DW'(1)) ? fc + DW'(1) :
             (int'(end_col_reg) > MAX_WIDTH) ? DW'(MAX_WIDTH) : end_col_reg;
        dw = ec - fc;
        point = (sw > dw) || (sh > dh) ||
                ({sw, 1'b0} < {1'b0, dw}) || ({sh, 1'b0} < {1'b0, dh});
    end

    assign load_inc = CNT_W'(load_idx_reg) + CNT_W'(1);
    assign area     = CNT_W'(sw) * CNT_W'(sh);

    // divisions: prev row, cur row, prev column, cur column
    assign div_i = k_reg[1] ? c_reg : row_reg;
    assign div_s = k_reg[1] ? sw : sh;
    assign div_req.start = (state_reg == irs_pkg::ST_MUL);
    assign div_req.num   = {(2*DW)'(div_i + DW'(k_reg[0])) * (2*DW)'(div_s), 8'b0};
    assign div_req.den   = k_reg[1] ? dw : dh;

    irs_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quo   (div_quo)
    );

    // texel positions and weights
    always_comb
    begin
        r0 = res_reg[0][irs_pkg::Q_W-1:8];
        c0 = res_reg[2][irs_pkg::Q_W-1:8];
        r1_t = ({1'b0, row_reg} + (DW+1)'(1) < {1'b0, dh}) ?
               {1'b0, r0} + (DW+1)'(1) : {1'b0, r0};
        c1_t = ({1'b0, c_reg} + (DW+1)'(1) < {1'b0, dw}) ?
               {1'b0, c0} + (DW+1)'(1) : {1'b0, c0};
        r1 = (r1_t > {1'b0, sh - DW'(1)}) ? sh - DW'(1) : r1_t[DW-1:0];
        c1 = (c1_t > {1'b0, sw - DW'(1)}) ? sw - DW'(1) : c1_t[DW-1:0];
        top = ((res_reg[1][irs_pkg::Q_W-1:8] != res_reg[0][irs_pkg::Q_W-1:8]) &&
               (res_reg[1][7:0] != 8'd0)) ? {1'b0, res_reg[1][7:0]} : DW'(256);
        left = ((res_reg[3][irs_pkg::Q_W-1:8] != res_reg[2][irs_pkg::Q_W-1:8]) &&
                (res_reg[3][7:0] != 8'd0)) ? {1'b0, res_reg[3][7:0]} : DW'(256);
        tex_r = tj_reg[1] ? r1 : r0;
        tex_c = tj_reg[0] ? c1 : c0;
        wa = tj_reg[0] ? DW'(256) - left : left;
        wb = tj_reg[1] ? DW'(256) - top : top;
        tex_prod = (2*DW)'(tex_r) * (2*DW)'(sw);
        tex_addr = ADR_W'(tex_prod + (2*DW)'(tex_c));
    end

    always_comb
    begin
        sum_acc[0] = sum_reg[0] + irs_pkg::SUM_W'(rd_data_reg[23:16]) *
                     irs_pkg::SUM_W'(w_reg);
        sum_acc[1] = sum_reg[1] + irs_pkg::SUM_W'(rd_data_reg[15:8]) *
                     irs_pkg::SUM_W'(w_reg);
        sum_acc[2] = sum_reg[2] + irs_pkg::SUM_W'(rd_data_reg[7:0]) *
                     irs_pkg::SUM_W'(w_reg);
    end

    assign row_n   = (out_row_reg >= dh) ? '0 : out_row_reg;
    assign col_n   = (out_col_reg < fc || out_col_reg >= ec) ? fc : out_col_reg;
    assign col_inc = {1'b0, col_reg} + (DW+1)'(1);
    assign row_inc = {1'b0, row_reg} + (DW+1)'(1);

    always_comb
    begin
        state_next      = state_reg;
        load_idx_next   = load_idx_reg;
        out_row_next    = out_row_reg;
        out_col_next    = out_col_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        c_next          = c_reg;
        k_next          = k_reg;
        tj_next         = tj_reg;
        res_next        = res_reg;
        w_next          = w_reg;
        sum_next        = sum_reg;
        dest_pixel_next = dest_pixel_reg;
        last_next       = last_reg;
        done_next       = 1'b0;
        mem_we          = 1'b0;
        unique case (state_reg)
            irs_pkg::ST_IDLE:
            begin
                if (start && !cmd)
                begin
                    mem_we = 1'b1;
                    load_idx_next = (load_inc >= area) ? '0 : load_inc[ADR_W-1:0];
                end
                else if (start)
                begin
                    row_next   = row_n;
                    col_next   = col_n;
                    c_next     = col_n - fc;
                    k_next     = '0;
                    sum_next   = '{default: '0};
                    state_next = irs_pkg::ST_MUL;
                end
            end
            irs_pkg::ST_MUL:
            begin
                state_next = irs_pkg::ST_DIV;
            end
            irs_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    res_next[k_reg] = div_quo;
                    k_next = k_reg + 2'd1;
                    tj_next = '0;
                    state_next = (k_reg == 2'd3) ? irs_pkg::ST_READ : irs_pkg::ST_MUL;
                end
            end
            irs_pkg::ST_READ:
            begin
                w_next = irs_pkg::W_W'(wa) * irs_pkg::W_W'(wb);
                state_next = irs_pkg::ST_ACC;
            end
            irs_pkg::ST_ACC:
            begin
                sum_next = sum_acc;
                if (point || tj_reg == 2'd3)
                begin
                    dest_pixel_next = point ? irs_pkg::pack_1555(rd_data_reg) :
                        {1'b1, sum_acc[0][23:19], sum_acc[1][23:19], sum_acc[2][23:19]};
                    last_next = (row_reg == dh - DW'(1)) && (c_reg == dw - DW'(1));
                    done_next = 1'b1;
                    // advance the output position, wrapping at row and image end
                    if (col_inc >= {1'b0, ec})
                    begin
                        out_col_next = fc;
                        out_row_next = (row_inc >= {1'b0, dh}) ? '0 : row_inc[DW-1:0];
                    end
                    else
                    begin
                        out_col_next = col_inc[DW-1:0];
                        out_row_next = row_reg;
                    end
                    state_next = irs_pkg::ST_IDLE;
                end
                else
                begin
                    tj_next = tj_reg + 2'd1;
                    state_next = irs_pkg::ST_READ;
                end
            end
            default:
            begin
                state_next = irs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= irs_pkg::ST_IDLE;
            load_idx_reg <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            k_reg        <= '0;
            tj_reg       <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            load_idx_reg <= load_idx_next;
            out_row_reg  <= out_row_next;
            out_col_reg  <= out_col_next;
            k_reg        <= k_next;
            tj_reg       <= tj_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg        <= row_next;
        col_reg        <= col_next;
        c_reg          <= c_next;
        res_reg        <= res_next;
        w_reg          <= w_next;
        sum_reg        <= sum_next;
        dest_pixel_reg <= dest_pixel_next;
        last_reg       <= last_next;
    end

    // single-port pixel memory: loads write while idle, texel reads otherwise
    assign mem_addr = (state_reg == irs_pkg::ST_IDLE) ? load_idx_reg : tex_addr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= pixel[irs_pkg::PIX_W-1:0];
        end
        else
        begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    assign busy       = (state_reg != irs_pkg::ST_IDLE);
    assign done       = done_reg;
    assign dest_pixel = dest_pixel_reg;
    assign last       = last_reg;

    `IRS_ASSERT_NOW(a_done_idle, clk, rst_n, done, !busy && dest_pixel[15])
    `IRS_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done)
    `IRS_ASSERT_NEXT(a_load_quiet, clk, rst_n, start && !busy && !cmd, !done && !busy)
    `IRS_ASSERT_NEXT(a_produce_busy, clk, rst_n, start && !busy && cmd, busy)

endmodule
